// File: src/wps_pkg.sv
// ----------------------------------------------------------------------------
// Watering pump scheduler package
// Shared constants, field widths, codes and transaction structs.
// ----------------------------------------------------------------------------
package wps_pkg;

    localparam int POTS     = 4;
    localparam int POT_W    = (POTS > 1) ? $clog2(POTS) : 1;
    localparam int SEL_W    = 2;
    localparam int LEVEL_W  = 10;
    localparam int TIME_W   = 32;
    localparam int PROD_W   = TIME_W + LEVEL_W;
    localparam int SPAN_MIN = 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVER  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT  = 3'd5;

    localparam logic [LEVEL_W-1:0] TRIGGER_RST  = 10'd400;
    localparam logic [LEVEL_W-1:0] RECOVER_RST  = 10'd600;
    localparam logic [TIME_W-1:0]  COOLDOWN_RST = 32'd600000;
    localparam logic [TIME_W-1:0]  BASE_RST     = 32'd2000;
    localparam logic [TIME_W-1:0]  MAX_RST      = 32'd8000;
    localparam logic [TIME_W-1:0]  LOCKOUT_RST  = 32'd30000;

    typedef enum logic [0:0] {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_START = 2'd1,
        EV_STOP  = 2'd2
    } t_event;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_PREP,
        S_MUL,
        S_DIV_GO,
        S_DIV,
        S_STOP_CHK,
        S_STOP_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [LEVEL_W-1:0] trigger_level;
        logic [LEVEL_W-1:0] recover_level;
        logic [TIME_W-1:0]  cooldown_ms;
        logic [TIME_W-1:0]  base_pump_ms;
        logic [TIME_W-1:0]  max_pump_ms;
        logic [TIME_W-1:0]  startup_lockout_ms;
    } t_cfg;

    typedef struct packed {
        logic [SEL_W-1:0]   pot_select;
        logic [LEVEL_W-1:0] moisture_level;
        logic               probe_fault;
        logic [TIME_W-1:0]  now_ms;
        logic               control_due;
    } t_item;

    typedef struct packed {
        t_event             event_res;
        logic [SEL_W-1:0]   event_pot;
        logic [TIME_W-1:0]  run_time_ms;
        logic [TIME_W-1:0]  watering_count;
        logic               pump_busy;
        logic [SEL_W-1:0]   running_pot;
    } t_result;

endpackage

// File: src/watering_pump_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Watering pump scheduler unit
// Moisture samples and time ticks in, one pump event transaction out per item.
// ----------------------------------------------------------------------------
// One item is worked on at a time; the next is taken once its result has
// moved to the output register. A sample only updates its pot's record. A
// tick that may start a pump searches the pots, reading each pot's records
// in turn; one that finds a pot adds the run time calculation, mostly the
// serial divider producing one quotient bit per cycle over 42 bits. A tick
// then checks whether the running pump is due to stop, so a new run of zero
// length stops at once. While the output side holds off, the finished result
// waits and no new item is taken.
module watering_pump_scheduler_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // pot_select[1:0], moisture_level[11:2], probe_fault[12], now_ms[44:13],
    // control_due[45], zero[47:46]
    input  logic [wps_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // opcode[0]
    input  logic [wps_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // event_pot[1:0], run_time_ms[33:2], watering_count[65:34], pump_busy[66],
    // running_pot[68:67], zero[71:69]
    output logic [wps_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // event_res[1:0]
    output logic [wps_pkg::M_TUSER_W-1:0]   m_axis_tuser,
    input  logic                            i_cfg_we,
    input  logic [wps_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [wps_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import wps_pkg::*;

    t_cfg    r_cfg;
    t_item   item;
    t_opcode opcode;
    t_result core_res;
    t_result r_m_res;
    logic    r_m_valid;
    logic    core_idle, core_res_valid, slot_free;

    always_comb begin
        item.pot_select     = s_axis_tdata[1:0];
        item.moisture_level = s_axis_tdata[11:2];
        item.probe_fault    = s_axis_tdata[12];
        item.now_ms         = s_axis_tdata[44:13];
        item.control_due    = s_axis_tdata[45];
        opcode              = t_opcode'(s_axis_tuser[0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_level      <= TRIGGER_RST;
            r_cfg.recover_level      <= RECOVER_RST;
            r_cfg.cooldown_ms        <= COOLDOWN_RST;
            r_cfg.base_pump_ms       <= BASE_RST;
            r_cfg.max_pump_ms        <= MAX_RST;
            r_cfg.startup_lockout_ms <= LOCKOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TRIGGER:  r_cfg.trigger_level      <= i_cfg_data[LEVEL_W-1:0];
                CFG_RECOVER:  r_cfg.recover_level      <= i_cfg_data[LEVEL_W-1:0];
                CFG_COOLDOWN: r_cfg.cooldown_ms        <= i_cfg_data[TIME_W-1:0];
                CFG_BASE:     r_cfg.base_pump_ms       <= i_cfg_data[TIME_W-1:0];
                CFG_MAX:      r_cfg.max_pump_ms        <= i_cfg_data[TIME_W-1:0];
                CFG_LOCKOUT:  r_cfg.startup_lockout_ms <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    wps_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (s_axis_tvalid),
        .i_opcode    (opcode),
        .i_item      (item),
        .o_idle      (core_idle),
        .o_res_valid (core_res_valid),
        .i_res_ready (slot_free),
        .o_res       (core_res)
    );

    assign s_axis_tready = core_idle;
    assign slot_free     = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (core_res_valid && slot_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_res_valid && slot_free) begin
            r_m_res <= core_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_res.event_res;
    assign m_axis_tdata  = {3'b000, r_m_res.running_pot, r_m_res.pump_busy,
                            r_m_res.watering_count, r_m_res.run_time_ms,
                            r_m_res.event_pot};

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again right after a transaction");

    a_stop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (r_m_res.event_res == EV_STOP) |-> !r_m_res.pump_busy)
        else $error("pump still busy after stop event");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (r_m_res.event_res == EV_START) |->
            r_m_res.pump_busy && (r_m_res.running_pot == r_m_res.event_pot))
        else $error("start event without matching running pot");

    a_idle_pot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !r_m_res.pump_busy |-> (r_m_res.running_pot == '0))
        else $error("running pot reported while no pump runs");

endmodule

// File: src/wps_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module wps_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 4,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/wps_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle, for the run time scaling.
// ----------------------------------------------------------------------------
module wps_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [wps_pkg::PROD_W-1:0]  i_dividend,
    input  logic [wps_pkg::LEVEL_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [wps_pkg::TIME_W-1:0]  o_quotient
);
    import wps_pkg::*;

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [LEVEL_W-1:0] r_rem;
    logic [PROD_W-1:0]  r_quo;
    logic [LEVEL_W-1:0] r_div;

    logic [LEVEL_W:0]   shifted;
    logic [LEVEL_W:0]   diff;
    logic               ge;
    logic [LEVEL_W-1:0] n_rem;

    always_comb begin
        shifted = {r_rem, r_quo[PROD_W-1]};
        diff    = shifted - {1'b0, r_div};
        ge      = (shifted >= {1'b0, r_div});
        n_rem   = ge ? diff[LEVEL_W-1:0] : shifted[LEVEL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(PROD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[PROD_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[TIME_W-1:0];

endmodule

// File: src/wps_core.sv
// ----------------------------------------------------------------------------
// Scheduler core
// Per-pot records in two RAMs, pot scan, run time calculation, pump control.
// ----------------------------------------------------------------------------
module wps_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wps_pkg::t_cfg     i_cfg,
    input  logic              i_valid,
    input  wps_pkg::t_opcode  i_opcode,
    input  wps_pkg::t_item    i_item,
    output logic              o_idle,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output wps_pkg::t_result  o_res
);
    import wps_pkg::*;

    localparam int A_W = LEVEL_W + 1;
    localparam int B_W = 2 * TIME_W;

    t_state             r_state, n_state;
    t_item              r_item;
    logic [POT_W-1:0]   r_idx;
    logic               r_found, n_found;
    logic [POT_W-1:0]   r_best;
    logic [LEVEL_W-1:0] r_best_lvl;
    logic [LEVEL_W-1:0] r_deficit, r_span;
    logic [TIME_W-1:0]  r_diff;
    logic [PROD_W-1:0]  r_prod;
    logic               r_busy;
    logic [POT_W-1:0]   r_run_idx;
    logic [TIME_W-1:0]  r_start, r_len;
    t_event             r_ev;
    logic [POT_W-1:0]   r_ev_pot;
    logic [TIME_W-1:0]  r_cnt;
    logic [POTS-1:0]    r_vld_a, r_vld_b;

    logic               ram_a_we;
    logic [POT_W-1:0]   ram_a_waddr;
    logic [A_W-1:0]     ram_a_wdata, ram_a_rdata;
    logic               ram_b_we;
    logic [POT_W-1:0]   ram_b_raddr;
    logic [B_W-1:0]     ram_b_wdata, ram_b_rdata;
    logic               div_start, div_done;
    logic [TIME_W-1:0]  div_quo;

    logic               pot_ok, start_ok, stop_due, last_idx;
    logic [LEVEL_W-1:0] rd_lvl;
    logic               rd_fault, cooling, elig, take;
    logic [TIME_W-1:0]  rd_last, rd_cnt, stop_cnt;
    logic [LEVEL_W:0]   def_raw, span_raw;
    logic [LEVEL_W-1:0] def_c, span_c, def_clamp;
    logic [TIME_W-1:0]  diff_c;

    wps_ram #(.WIDTH(A_W), .DEPTH(POTS)) u_ram_level (
        .i_clk   (i_clk),
        .i_we    (ram_a_we),
        .i_waddr (ram_a_waddr),
        .i_wdata (ram_a_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_a_rdata)
    );

    wps_ram #(.WIDTH(B_W), .DEPTH(POTS)) u_ram_history (
        .i_clk   (i_clk),
        .i_we    (ram_b_we),
        .i_waddr (r_run_idx),
        .i_wdata (ram_b_wdata),
        .i_raddr (ram_b_raddr),
        .o_rdata (ram_b_rdata)
    );

    wps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_span),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        pot_ok      = (32'(i_item.pot_select) < 32'(POTS));
        ram_a_waddr = POT_W'(i_item.pot_select);
        ram_a_wdata = {i_item.moisture_level, i_item.probe_fault};
        start_ok    = i_item.control_due && !r_busy &&
                      (i_item.now_ms >= i_cfg.startup_lockout_ms);

        // entries never written read as their reset values
        rd_lvl   = r_vld_a[r_idx] ? ram_a_rdata[A_W-1:1] : '0;
        rd_fault = r_vld_a[r_idx] ? ram_a_rdata[0] : 1'b1;
        rd_last  = r_vld_b[r_idx] ? ram_b_rdata[B_W-1:TIME_W] : '0;
        rd_cnt   = r_vld_b[r_run_idx] ? ram_b_rdata[TIME_W-1:0] : '0;
        stop_cnt = rd_cnt + 1'b1;
        ram_b_wdata = {r_item.now_ms, stop_cnt};

        cooling  = (rd_last != '0) && ((r_item.now_ms - rd_last) < i_cfg.cooldown_ms);
        elig     = !rd_fault && !cooling && (rd_lvl <= i_cfg.trigger_level);
        take     = elig && (!r_found || (rd_lvl < r_best_lvl));
        n_found  = r_found || elig;
        last_idx = (r_idx == POT_W'(POTS - 1));
        stop_due = r_busy && ((r_item.now_ms - r_start) >= r_len);

        def_raw  = {1'b0, i_cfg.trigger_level} - {1'b0, r_best_lvl};
        span_raw = {1'b0, i_cfg.recover_level} - {1'b0, i_cfg.trigger_level};
        def_c    = def_raw[LEVEL_W] ? '0 : def_raw[LEVEL_W-1:0];
        span_c   = (span_raw[LEVEL_W] || (span_raw[LEVEL_W-1:0] < LEVEL_W'(SPAN_MIN))) ?
                   LEVEL_W'(SPAN_MIN) : span_raw[LEVEL_W-1:0];
        def_clamp = (def_c > span_c) ? span_c : def_c;
        diff_c   = (i_cfg.max_pump_ms >= i_cfg.base_pump_ms) ?
                   (i_cfg.max_pump_ms - i_cfg.base_pump_ms) : '0;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_opcode == OP_SAMPLE) begin
                        n_state = S_DONE;
                    end else if (start_ok) begin
                        n_state = S_SCAN_RD;
                    end else begin
                        n_state = S_STOP_CHK;
                    end
                end
            end
            S_SCAN_RD:  n_state = S_SCAN_EV;
            S_SCAN_EV: begin
                if (last_idx) begin
                    n_state = n_found ? S_PREP : S_STOP_CHK;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_PREP:     n_state = S_MUL;
            S_MUL:      n_state = S_DIV_GO;
            S_DIV_GO:   n_state = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_STOP_CHK;
                end
            end
            S_STOP_CHK: n_state = stop_due ? S_STOP_WR : S_DONE;
            S_STOP_WR:  n_state = S_DONE;
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_idle      = 1'b0;
        o_res_valid = 1'b0;
        ram_a_we    = 1'b0;
        ram_b_we    = 1'b0;
        ram_b_raddr = r_idx;
        div_start   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_idle   = 1'b1;
                ram_a_we = i_valid && (i_opcode == OP_SAMPLE) && pot_ok;
            end
            S_DIV_GO:   div_start   = 1'b1;
            S_STOP_CHK: ram_b_raddr = r_run_idx;
            S_STOP_WR:  ram_b_we    = 1'b1;
            S_DONE:     o_res_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_busy    <= 1'b0;
            r_run_idx <= '0;
            r_start   <= '0;
            r_len     <= '0;
            r_vld_a   <= '0;
            r_vld_b   <= '0;
            r_ev      <= EV_NONE;
            r_ev_pot  <= '0;
            r_cnt     <= '0;
            r_found   <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state <= n_state;
            if (ram_a_we) begin
                r_vld_a[ram_a_waddr] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_ev     <= EV_NONE;
                        r_ev_pot <= '0;
                        r_cnt    <= '0;
                        r_found  <= 1'b0;
                        r_idx    <= '0;
                    end
                end
                S_SCAN_EV: begin
                    r_found <= n_found;
                    if (!last_idx) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_len     <= i_cfg.base_pump_ms + div_quo;
                        r_start   <= r_item.now_ms;
                        r_run_idx <= r_best;
                        r_busy    <= 1'b1;
                        r_ev      <= EV_START;
                        r_ev_pot  <= r_best;
                    end
                end
                S_STOP_WR: begin
                    r_vld_b[r_run_idx] <= 1'b1;
                    r_busy   <= 1'b0;
                    r_ev     <= EV_STOP;
                    r_ev_pot <= r_run_idx;
                    r_cnt    <= stop_cnt;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_item <= i_item;
                end
            end
            S_SCAN_EV: begin
                if (take) begin
                    r_best     <= r_idx;
                    r_best_lvl <= rd_lvl;
                end
            end
            S_PREP: begin
                r_deficit <= def_clamp;
                r_span    <= span_c;
                r_diff    <= diff_c;
            end
            S_MUL:   r_prod <= PROD_W'(r_diff) * PROD_W'(r_deficit);
            default: ;
        endcase
    end

    always_comb begin
        o_res.event_res      = r_ev;
        o_res.event_pot      = SEL_W'(r_ev_pot);
        o_res.run_time_ms    = ((r_ev != EV_NONE) || r_busy) ? r_len : '0;
        o_res.watering_count = r_cnt;
        o_res.pump_busy      = r_busy;
        o_res.running_pot    = r_busy ? SEL_W'(r_run_idx) : '0;
    end

endmodule

// File: tb/tb_watering_pump_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Watering pump scheduler unit testbench
// Drives moisture samples and time ticks through the input stream and scores
// every pump event transaction against a cycle-free scheduler model kept in
// the bench or a result fixed in a directed table covering lockout, faults,
// ties, cooldown, wrap, zero-length runs, out-of-range levels; random phases
// follow, with fresh register settings, random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_watering_pump_scheduler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import wps_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 11;
    localparam int PHASE_ITEMS = 95;
    localparam int HOLD_OFF    = 300;

    typedef enum logic {
        ROW_ITEM,
        ROW_REG
    } t_row_kind;

    typedef struct {
        t_row_kind             kind;
        t_opcode               op;
        t_item                 item;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                  fixed;
        t_result               res;
    } t_row;

    localparam t_result NO_EVENT = '0;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    logic [S_TUSER_W-1:0]   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [M_TUSER_W-1:0]   m_axis_tuser;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    // scheduler model state
    t_cfg               cfg_q;
    logic [LEVEL_W-1:0] pot_level   [POTS];
    logic               pot_fault   [POTS];
    logic [TIME_W-1:0]  pot_last_ms [POTS];
    logic [TIME_W-1:0]  pot_count   [POTS];
    logic               pump_on;
    logic [SEL_W-1:0]   pump_pot;
    logic [TIME_W-1:0]  pump_t0;
    logic [TIME_W-1:0]  pump_len;

    t_result pending_events[$];
    int      err_cnt  = 0;
    int      rx_cnt   = 0;
    int      tx_gap   = 0;
    logic    tx_burst = 1'b0;

    always #1 i_clk = ~i_clk;

    watering_pump_scheduler_unit u_dut (.*);

    function automatic logic [TIME_W-1:0] pump_duration(logic [LEVEL_W-1:0] level);
        int                deficit;
        int                span;
        logic [TIME_W-1:0] headroom;
        logic [63:0]       extra;
        deficit  = int'(cfg_q.trigger_level) - int'(level);
        span     = int'(cfg_q.recover_level) - int'(cfg_q.trigger_level);
        headroom = cfg_q.max_pump_ms - cfg_q.base_pump_ms;
        extra    = '0;
        if (deficit < 0) deficit = 0;
        if (span < SPAN_MIN) span = SPAN_MIN;
        if (deficit > span) deficit = span;
        if (cfg_q.max_pump_ms >= cfg_q.base_pump_ms)
            extra = ({32'd0, headroom} * 64'(deficit)) / 64'(span);
        return cfg_q.base_pump_ms + extra[TIME_W-1:0];
    endfunction

    function automatic t_result next_pump_event(t_opcode op, t_item item);
        t_result            r;
        logic               found;
        logic [SEL_W-1:0]   pick;
        logic [LEVEL_W-1:0] driest;
        int                 p;
        r      = NO_EVENT;
        found  = 1'b0;
        pick   = '0;
        driest = '0;
        if (op == OP_SAMPLE) begin
            pot_level[item.pot_select] = item.moisture_level;
            pot_fault[item.pot_select] = item.probe_fault;
        end else begin
            if (item.control_due && !pump_on &&
                item.now_ms >= cfg_q.startup_lockout_ms) begin
                for (p = 0; p < POTS; p++) begin
                    if (!pot_fault[p] && pot_level[p] <= cfg_q.trigger_level &&
                        (pot_last_ms[p] == '0 ||
                         item.now_ms - pot_last_ms[p] >= cfg_q.cooldown_ms) &&
                        (!found || pot_level[p] < driest)) begin
                        found  = 1'b1;
                        pick   = SEL_W'(p);
                        driest = pot_level[p];
                    end
                end
                if (found) begin
                    pump_len      = pump_duration(driest);
                    pump_t0       = item.now_ms;
                    pump_pot      = pick;
                    pump_on       = 1'b1;
                    r.event_res   = EV_START;
                    r.event_pot   = pick;
                    r.run_time_ms = pump_len;
                end
            end
            if (pump_on && item.now_ms - pump_t0 >= pump_len) begin
                pot_last_ms[pump_pot] = item.now_ms;
                pot_count[pump_pot]   = pot_count[pump_pot] + 1;
                pump_on               = 1'b0;
                r.event_res           = EV_STOP;
                r.event_pot           = pump_pot;
                r.run_time_ms         = pump_len;
                r.watering_count      = pot_count[pump_pot];
            end
        end
        if (r.event_res == EV_NONE && pump_on) r.run_time_ms = pump_len;
        r.pump_busy   = pump_on;
        r.running_pot = pump_on ? pump_pot : '0;
        return r;
    endfunction

    function automatic t_row blank_row();
        t_row r;
        r.kind    = ROW_ITEM;
        r.op      = OP_SAMPLE;
        r.item    = '0;
        r.reg_idx = '0;
        r.reg_val = '0;
        r.fixed   = 1'b0;
        r.res     = NO_EVENT;
        return r;
    endfunction

    function automatic t_row sample_row(logic [SEL_W-1:0] pot, logic [LEVEL_W-1:0] level,
                                        logic fault);
        t_row r;
        r                     = blank_row();
        r.item.pot_select     = pot;
        r.item.moisture_level = level;
        r.item.probe_fault    = fault;
        return r;
    endfunction

    function automatic t_row tick_row(logic [TIME_W-1:0] now, logic due);
        t_row r;
        r                  = blank_row();
        r.op               = OP_TICK;
        r.item.now_ms      = now;
        r.item.control_due = due;
        return r;
    endfunction

    function automatic t_row reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        t_row r;
        r         = blank_row();
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic t_row fixed_row(t_row r, t_result res);
        t_row f;
        f       = r;
        f.fixed = 1'b1;
        f.res   = res;
        return f;
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 10'd1000;
            2:       return 10'd1023;
            3:       return 10'($urandom_range(1001, 1023));
            default: return 10'($urandom_range(0, 1000));
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(0, 9))
            0:          return '0;
            1:          return 32'hFFFF_FFFF;
            2, 3, 4, 5: return 32'($urandom_range(0, 300));
            6, 7:       return 32'($urandom_range(0, 5000));
            default:    return 32'($urandom);
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TRIGGER:  cfg_q.trigger_level      = val[LEVEL_W-1:0];
            CFG_RECOVER:  cfg_q.recover_level      = val[LEVEL_W-1:0];
            CFG_COOLDOWN: cfg_q.cooldown_ms        = val;
            CFG_BASE:     cfg_q.base_pump_ms       = val;
            CFG_MAX:      cfg_q.max_pump_ms        = val;
            CFG_LOCKOUT:  cfg_q.startup_lockout_ms = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // stop offering and wait until every pending transaction has come back
    task automatic drain();
        if (tx_gap == 0) s_axis_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic send_item(t_opcode op, t_item item, logic fixed, t_result res);
        t_result want;
        repeat (tx_gap) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, item.control_due, item.now_ms, item.probe_fault,
                          item.moisture_level, item.pot_select};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        want = next_pump_event(op, item);
        pending_events.push_back(fixed ? res : want);
        tx_gap = tx_burst ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
        if (tx_gap != 0) s_axis_tvalid <= 1'b0;
    endtask

    initial begin : rx_side
        int      stall;
        logic    rx_burst;
        t_result got;
        t_result want;
        rx_burst = 1'b0;
        m_axis_tready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 10);
            if (rx_cnt == 400) stall = HOLD_OFF;
            if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            rx_cnt++;
            got.event_res      = t_event'(m_axis_tuser[1:0]);
            got.event_pot      = m_axis_tdata[1:0];
            got.run_time_ms    = m_axis_tdata[33:2];
            got.watering_count = m_axis_tdata[65:34];
            got.pump_busy      = m_axis_tdata[66];
            got.running_pot    = m_axis_tdata[68:67];
            if (pending_events.size() == 0) begin
                err_cnt++;
                $error("unexpected transaction: event_res %0d event_pot %0d",
                       got.event_res, got.event_pot);
            end else begin
                want = pending_events.pop_front();
                if (got.event_res !== want.event_res) begin
                    err_cnt++;
                    $error("event_res: expected %0d, got %0d", want.event_res, got.event_res);
                end
                if (got.event_pot !== want.event_pot) begin
                    err_cnt++;
                    $error("event_pot: expected %0d, got %0d", want.event_pot, got.event_pot);
                end
                if (got.run_time_ms !== want.run_time_ms) begin
                    err_cnt++;
                    $error("run_time_ms: expected %0d, got %0d",
                           want.run_time_ms, got.run_time_ms);
                end
                if (got.watering_count !== want.watering_count) begin
                    err_cnt++;
                    $error("watering_count: expected %0d, got %0d",
                           want.watering_count, got.watering_count);
                end
                if (got.pump_busy !== want.pump_busy) begin
                    err_cnt++;
                    $error("pump_busy: expected %0d, got %0d", want.pump_busy, got.pump_busy);
                end
                if (got.running_pot !== want.running_pot) begin
                    err_cnt++;
                    $error("running_pot: expected %0d, got %0d",
                           want.running_pot, got.running_pot);
                end
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_watering_pump_scheduler_unit: done, errors");
        $finish;
    end

    initial begin : stimulus
        t_row              rows[$];
        t_item             item;
        t_opcode           op;
        logic [TIME_W-1:0] clock_ms;
        int                step_max;
        int                k;
        int                ph;
        int                n;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        cfg_q = '{TRIGGER_RST, RECOVER_RST, COOLDOWN_RST, BASE_RST, MAX_RST, LOCKOUT_RST};
        for (k = 0; k < POTS; k++) begin
            pot_level[k]   = '0;
            pot_fault[k]   = 1'b1;
            pot_last_ms[k] = '0;
            pot_count[k]   = '0;
        end
        pump_on  = 1'b0;
        pump_pot = '0;
        pump_t0  = '0;
        pump_len = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // lockout, then every pot still faulty from reset
        rows.push_back(fixed_row(tick_row(32'd0, 1'b1), NO_EVENT));
        rows.push_back(fixed_row(tick_row(32'd100000, 1'b1), NO_EVENT));
        rows.push_back(fixed_row(sample_row(2'd0, 10'd1000, 1'b0), NO_EVENT));
        rows.push_back(fixed_row(sample_row(2'd1, 10'd0, 1'b0), NO_EVENT));
        rows.push_back(fixed_row(sample_row(2'd2, 10'd0, 1'b0), NO_EVENT));
        rows.push_back(fixed_row(sample_row(2'd3, 10'd1023, 1'b1), NO_EVENT));
        // tie between pots 1 and 2, full deficit
        rows.push_back(fixed_row(tick_row(32'd100000, 1'b1),
                                 t_result'{EV_START, 2'd1, 32'd8000, 32'd0, 1'b1, 2'd1}));
        rows.push_back(tick_row(32'd107999, 1'b0));
        rows.push_back(fixed_row(tick_row(32'd108000, 1'b1),
                                 t_result'{EV_STOP, 2'd1, 32'd8000, 32'd1, 1'b0, 2'd0}));
        rows.push_back(sample_row(2'd2, 10'd300, 1'b0));
        rows.push_back(tick_row(32'd108001, 1'b1));
        rows.push_back(tick_row(32'hFFFF_FFFF, 1'b0));
        rows.push_back(sample_row(2'd0, 10'd400, 1'b0));
        // zero-length run: start and stop in one tick, stop recorded at time 0
        rows.push_back(reg_row(CFG_LOCKOUT, 32'd0));
        rows.push_back(reg_row(CFG_BASE, 32'd0));
        rows.push_back(reg_row(CFG_MAX, 32'd0));
        rows.push_back(fixed_row(tick_row(32'd0, 1'b1),
                                 t_result'{EV_STOP, 2'd1, 32'd0, 32'd2, 1'b0, 2'd0}));
        rows.push_back(tick_row(32'd1, 1'b1));
        // level above full scale still chosen, max below base
        rows.push_back(reg_row(CFG_TRIGGER, 32'd1023));
        rows.push_back(reg_row(CFG_RECOVER, 32'd0));
        rows.push_back(reg_row(CFG_BASE, 32'd5));
        rows.push_back(reg_row(CFG_MAX, 32'd3));
        rows.push_back(reg_row(CFG_COOLDOWN, 32'hFFFF_FFFF));
        rows.push_back(sample_row(2'd0, 10'd0, 1'b1));
        rows.push_back(sample_row(2'd1, 10'd0, 1'b1));
        rows.push_back(sample_row(2'd2, 10'd0, 1'b1));
        rows.push_back(sample_row(2'd3, 10'd1023, 1'b0));
        rows.push_back(fixed_row(tick_row(32'd500, 1'b1),
                                 t_result'{EV_START, 2'd3, 32'd5, 32'd0, 1'b1, 2'd3}));
        rows.push_back(tick_row(32'd505, 1'b1));
        rows.push_back(fixed_row(tick_row(32'd506, 1'b1), NO_EVENT));
        // full-scale run time, stopped by a wrapped time difference
        rows.push_back(reg_row(CFG_BASE, 32'd0));
        rows.push_back(reg_row(CFG_MAX, 32'hFFFF_FFFF));
        rows.push_back(reg_row(CFG_TRIGGER, 32'd1000));
        rows.push_back(reg_row(CFG_RECOVER, 32'd1000));
        rows.push_back(reg_row(CFG_COOLDOWN, 32'd0));
        rows.push_back(sample_row(2'd1, 10'd0, 1'b0));
        rows.push_back(fixed_row(tick_row(32'd1000, 1'b1),
                                 t_result'{EV_START, 2'd1, 32'hFFFF_FFFF, 32'd0, 1'b1, 2'd1}));
        rows.push_back(tick_row(32'd999, 1'b0));

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_REG) begin
                drain();
                write_reg(rows[i].reg_idx, rows[i].reg_val);
            end else begin
                send_item(rows[i].op, rows[i].item, rows[i].fixed, rows[i].res);
            end
        end

        clock_ms = 32'd1000;
        for (ph = 0; ph < PHASES; ph++) begin
            drain();
            write_reg(CFG_TRIGGER, 32'(pick_level()));
            write_reg(CFG_RECOVER, 32'(pick_level()));
            write_reg(CFG_COOLDOWN, pick_time());
            write_reg(CFG_BASE, pick_time());
            write_reg(CFG_MAX, pick_time());
            write_reg(CFG_LOCKOUT, pick_time());
            step_max = $urandom_range(1, 400);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 5 && n == 40) drain();
                item.pot_select     = 2'($urandom_range(0, 3));
                item.moisture_level = pick_level();
                item.probe_fault    = ($urandom_range(0, 7) == 0);
                item.now_ms         = $urandom;
                item.control_due    = ($urandom_range(0, 3) != 0);
                op = ($urandom_range(0, 4) < 2) ? OP_SAMPLE : OP_TICK;
                if (op == OP_TICK) begin
                    if ($urandom_range(0, 24) == 0)
                        clock_ms = $urandom;
                    else
                        clock_ms = clock_ms + 32'($urandom_range(0, step_max));
                    item.now_ms = clock_ms;
                end
                send_item(op, item, 1'b0, NO_EVENT);
            end
        end

        drain();
        repeat (80) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb_watering_pump_scheduler_unit: done, clean");
        end else begin
            $display("tb_watering_pump_scheduler_unit: done, errors");
        end
        $finish;
    end

endmodule
